FILE: rtl/core/kvs_pkg.sv
// kvs_pkg: shared types and constants of the keyframe vec3 sampler
// no dependencies; imported by the interfaces and every module of the block but kvs_ram
`default_nettype none

package kvs_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int FRAC_BITS = 16;
    localparam int KEY_AW    = $clog2(MAX_KEYS);
    localparam int CNT_W     = 7;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 3;

    localparam logic [PADDR_W-1:0] ADDR_MODE  = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_COUNT = 3'd4;

    localparam logic [1:0] MODE_STEP   = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                 kind;
        logic [KEY_AW-1:0]         idx;
        logic signed [DATA_W-1:0]  tm;
        logic signed [DATA_W-1:0]  vx;
        logic signed [DATA_W-1:0]  vy;
        logic signed [DATA_W-1:0]  vz;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/core/kvs_if.sv
// kvs_in_if / kvs_out_if: valid-ready channels of the sampler
// depend on kvs_pkg for the field widths
`default_nettype none

interface kvs_in_if;
    import kvs_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [KEY_AW-1:0]         key_index;
    logic signed [DATA_W-1:0]  key_time;
    logic signed [DATA_W-1:0]  value_x;
    logic signed [DATA_W-1:0]  value_y;
    logic signed [DATA_W-1:0]  value_z;
    logic signed [DATA_W-1:0]  sample_time;

    modport source (output valid, action, key_index, key_time, value_x, value_y, value_z,
                    sample_time, input ready);
    modport sink (input valid, action, key_index, key_time, value_x, value_y, value_z,
                  sample_time, output ready);
endinterface

interface kvs_out_if;
    import kvs_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  out_x;
    logic signed [DATA_W-1:0]  out_y;
    logic signed [DATA_W-1:0]  out_z;
    logic [KEY_AW-1:0]         bracket_index;

    modport source (output valid, out_x, out_y, out_z, bracket_index, input ready);
    modport sink (input valid, out_x, out_y, out_z, bracket_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/kvs_ram.sv
// kvs_ram: generic single-write, single-read ram with registered read
// no dependencies
`default_nettype none

module kvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/kvs_front.sv
// kvs_front: accepts input transfers, classifies them into commands, two-entry queue
// depends on kvs_pkg and kvs_in_if
`default_nettype none

module kvs_front
    import kvs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kvs_in_if.sink    i_in,
    output logic      o_cmd_valid,
    output t_cmd      o_cmd,
    input  wire logic i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_cmd       cmd_in;

    assign i_in.ready  = (r_cnt != 2'd2);
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        cmd_in.kind = i_in.action ? CMD_SAMPLE : CMD_WRITE;
        cmd_in.idx  = i_in.key_index;
        cmd_in.tm   = i_in.action ? i_in.sample_time : i_in.key_time;
        cmd_in.vx   = i_in.value_x;
        cmd_in.vy   = i_in.value_y;
        cmd_in.vz   = i_in.value_z;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/kvs_back.sv
// kvs_back: key table, bracket search, alpha divider, interpolation, output register
// depends on kvs_pkg, kvs_ram and kvs_out_if
`default_nettype none

module kvs_back
    import kvs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cmd_valid,
    input  t_cmd                  i_cmd,
    output logic                  o_cmd_pop,
    input  wire logic [1:0]       i_mode,
    input  wire logic [CNT_W-1:0] i_key_count,
    kvs_out_if.source             o_out
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_FIRST, ST_LAST, ST_SRCH, ST_CMP, ST_FETCH,
        ST_GETA, ST_GETB, ST_DIV, ST_MUL, ST_ADD, ST_OUT
    } t_state;

    localparam int VW = 3 * DATA_W;
    localparam int PW = DATA_W + 1 + FRAC_BITS + 2;

    t_state                   r_state;
    logic signed [DATA_W-1:0] r_t;
    logic [CNT_W-1:0]         r_count;
    logic [1:0]               r_mode;
    logic [KEY_AW-1:0]        r_lo;
    logic [KEY_AW-1:0]        r_hi;
    logic [KEY_AW-1:0]        r_i;
    logic signed [DATA_W-1:0] r_ta;
    logic signed [DATA_W-1:0] r_va [3];
    logic signed [DATA_W-1:0] r_vb [3];
    logic [DATA_W:0]          r_dt;
    logic [DATA_W-1:0]        r_rem;
    logic [FRAC_BITS-1:0]     r_q;
    logic [4:0]               r_dcnt;
    logic signed [PW-1:0]     r_p [3];
    logic signed [DATA_W-1:0] r_res [3];
    logic [KEY_AW-1:0]        r_res_idx;
    logic                     r_o_valid;
    logic signed [DATA_W-1:0] r_o [3];
    logic [KEY_AW-1:0]        r_o_idx;

    logic                     we;
    logic [KEY_AW-1:0]        raddr;
    logic signed [DATA_W-1:0] rd_t;
    logic [VW-1:0]            rd_v;
    logic signed [DATA_W-1:0] rd_c [3];
    logic [CNT_W-1:0]         cnt_sat;
    logic [KEY_AW-1:0]        last;
    logic [CNT_W-1:0]         mid_sum;
    logic [KEY_AW-1:0]        mid;
    logic signed [DATA_W:0]   num;
    logic signed [DATA_W:0]   dt;
    logic [DATA_W:0]          rem2;
    logic                     step;
    logic                     out_free;

    function automatic logic signed [DATA_W-1:0] sat(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi_lim;
        logic signed [PW-1:0] lo_lim;
        hi_lim = PW'({1'b0, {(DATA_W-1){1'b1}}});
        lo_lim = -hi_lim - PW'(1);
        if (v > hi_lim) begin
            return hi_lim[DATA_W-1:0];
        end else if (v < lo_lim) begin
            return lo_lim[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    assign cnt_sat  = (i_key_count > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : i_key_count;
    assign last     = KEY_AW'(r_count - CNT_W'(1));
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[KEY_AW:1];
    assign we       = (r_state == ST_IDLE) && i_cmd_valid && (i_cmd.kind == CMD_WRITE);
    assign o_cmd_pop = (r_state == ST_IDLE);
    assign num      = {r_t[DATA_W-1], r_t} - {r_ta[DATA_W-1], r_ta};
    assign dt       = {rd_t[DATA_W-1], rd_t} - {r_ta[DATA_W-1], r_ta};
    assign rem2     = {r_rem, 1'b0};
    assign step     = (r_mode == MODE_STEP) || (({1'b0, r_i} + CNT_W'(1)) >= r_count);
    assign out_free = !r_o_valid || o_out.ready;
    assign rd_c[0]  = rd_v[DATA_W-1:0];
    assign rd_c[1]  = rd_v[2*DATA_W-1:DATA_W];
    assign rd_c[2]  = rd_v[3*DATA_W-1:2*DATA_W];

    always_comb begin
        case (r_state)
            ST_FIRST: raddr = last;
            ST_SRCH:  raddr = mid;
            ST_FETCH: raddr = r_i;
            ST_GETA:  raddr = r_i + KEY_AW'(1);
            default:  raddr = '0;
        endcase
    end

    kvs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KEYS)) u_times (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_cmd.idx),
        .i_wdata (i_cmd.tm),
        .i_raddr (raddr),
        .o_rdata (rd_t)
    );

    kvs_ram #(.WIDTH(VW), .DEPTH(MAX_KEYS)) u_vals (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_cmd.idx),
        .i_wdata ({i_cmd.vz, i_cmd.vy, i_cmd.vx}),
        .i_raddr (raddr),
        .o_rdata (rd_v)
    );

    assign o_out.valid         = r_o_valid;
    assign o_out.out_x         = r_o[0];
    assign o_out.out_y         = r_o[1];
    assign o_out.out_z         = r_o[2];
    assign o_out.bracket_index = r_o_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_state == ST_OUT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid && i_cmd.kind == CMD_SAMPLE) begin
                        r_t     <= i_cmd.tm;
                        r_count <= cnt_sat;
                        r_mode  <= i_mode;
                        if (cnt_sat == '0) begin
                            r_res     <= '{default: '0};
                            r_res_idx <= '0;
                            r_state   <= ST_OUT;
                        end else begin
                            r_state <= ST_FIRST;
                        end
                    end
                end
                ST_FIRST: begin
                    if (r_t <= rd_t) begin
                        r_i     <= '0;
                        r_state <= ST_FETCH;
                    end else begin
                        r_state <= ST_LAST;
                    end
                end
                ST_LAST: begin
                    if (r_t >= rd_t) begin
                        r_i     <= last;
                        r_state <= ST_FETCH;
                    end else begin
                        r_lo    <= '0;
                        r_hi    <= last;
                        r_state <= ST_SRCH;
                    end
                end
                ST_SRCH: begin
                    if (({1'b0, r_lo} + CNT_W'(1)) < {1'b0, r_hi}) begin
                        r_state <= ST_CMP;
                    end else begin
                        r_i     <= r_lo;
                        r_state <= ST_FETCH;
                    end
                end
                ST_CMP: begin
                    if (rd_t <= r_t) begin
                        r_lo <= mid;
                    end else begin
                        r_hi <= mid;
                    end
                    r_state <= ST_SRCH;
                end
                ST_FETCH: begin
                    r_state <= ST_GETA;
                end
                ST_GETA: begin
                    r_ta      <= rd_t;
                    r_va      <= rd_c;
                    r_res     <= rd_c;
                    r_res_idx <= r_i;
                    r_state   <= step ? ST_OUT : ST_GETB;
                end
                ST_GETB: begin
                    r_vb   <= rd_c;
                    r_dt   <= dt;
                    r_rem  <= num[DATA_W-1:0];
                    r_q    <= '0;
                    r_dcnt <= 5'(FRAC_BITS - 1);
                    if (num > 0 && dt > 0) begin
                        r_state <= ST_DIV;
                    end else begin
                        r_state <= ST_MUL;
                    end
                end
                ST_DIV: begin
                    if (rem2 >= r_dt) begin
                        r_rem <= DATA_W'(rem2 - r_dt);
                        r_q   <= {r_q[FRAC_BITS-2:0], 1'b1};
                    end else begin
                        r_rem <= rem2[DATA_W-1:0];
                        r_q   <= {r_q[FRAC_BITS-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - 5'd1;
                    if (r_dcnt == '0) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    for (int c = 0; c < 3; c++) begin
                        r_p[c] <= PW'(($signed({r_vb[c][DATA_W-1], r_vb[c]}) -
                                       $signed({r_va[c][DATA_W-1], r_va[c]})) *
                                      $signed({2'b00, r_q}));
                    end
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    for (int c = 0; c < 3; c++) begin
                        r_res[c] <= sat(PW'(r_va[c]) + (r_p[c] >>> FRAC_BITS));
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_o       <= r_res;
                        r_o_idx   <= r_res_idx;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/keyframe_vec3_sampler_top.sv
// keyframe_vec3_sampler_top: apb registers, front queue and back sequencer
// depends on kvs_pkg, kvs_if, kvs_front and kvs_back
//
//   channel   dir  handshake        carries
//   i_in      in   valid/ready      action, key_index, key_time, value_x/y/z, sample_time
//   o_out     out  valid/ready      out_x, out_y, out_z, bracket_index
//   apb       in   psel/penable     interp_mode at 0x0, key_count at 0x4
//
// a write transfer is written to the key tables from the idle state of the back sequencer
// a sample takes two bound reads, up to six search reads of the time ram (each
// through ST_SRCH and ST_CMP, registered read), two key fetches, a 16-bit restoring
// divider for alpha, then multiply and add, which step mode and the last key skip
// the two-entry queue keeps taking transfers while the back part or the output stalls, until it is full
// synchronous active-low reset; key tables are not cleared
`default_nettype none

module keyframe_vec3_sampler_top
    import kvs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    kvs_in_if.sink                  i_in,
    kvs_out_if.source               o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready
);

    logic [1:0]       r_mode;
    logic [CNT_W-1:0] r_key_count;
    logic             cmd_valid;
    t_cmd             cmd;
    logic             cmd_pop;
    logic             wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_LINEAR;
            r_key_count <= '0;
        end else if (wr) begin
            if (paddr == ADDR_MODE) begin
                r_mode <= pwdata[1:0];
            end
            if (paddr == ADDR_COUNT) begin
                r_key_count <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_comb begin
        case (paddr)
            ADDR_MODE:  prdata = {{(DATA_W-2){1'b0}}, r_mode};
            ADDR_COUNT: prdata = {{(DATA_W-CNT_W){1'b0}}, r_key_count};
            default:    prdata = '0;
        endcase
    end

    kvs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    kvs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_mode      (r_mode),
        .i_key_count (r_key_count),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
